/* hdl/lr_pkg.sv */
// lr_pkg: shared types and defaults for the line rasterizer
// no dependencies; imported by every module of the block
package lr_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef enum logic {
        KIND_START = 1'b0,
        KIND_STEP  = 1'b1
    } kind_t;

endpackage

/* hdl/lr_front.sv */
// lr_front: accepts items, classifies them and precomputes line setup
// depends on lr_pkg; feeds lr_cmd_queue
module lr_front
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    parameter int CMD_W = 1 + 2 + (COORD_BITS + 2) + 6 * COORD_BITS
)
(
    input  logic [0:0]            kind,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    output logic [CMD_W-1:0]      cmd
);

    logic                         x_up;
    logic                         y_up;
    logic [COORD_BITS-1:0]        dx;
    logic [COORD_BITS-1:0]        dy;
    logic signed [COORD_BITS+1:0] err_init;

    always_comb
    begin
        x_up = x_start < x_end;
        y_up = y_start < y_end;
        dx = x_up ? (x_end - x_start) : (x_start - x_end);
        dy = y_up ? (y_end - y_start) : (y_start - y_end);
        err_init = $signed({2'b00, dx}) - $signed({2'b00, dy});
    end

    // field order must match the unpack in lr_back
    assign cmd = {kind, ~x_up, ~y_up, err_init, dy, dx, y_end, x_end, y_start, x_start};

endmodule

/* hdl/lr_cmd_queue.sv */
// lr_cmd_queue: short first-word-fall-through queue between front and back
// depends on lr_pkg for the default depth
module lr_cmd_queue
    import lr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");
`endif

endmodule

/* hdl/lr_back.sv */
// lr_back: holds the line state, runs the bresenham steps, registers results
// depends on lr_pkg; consumes commands built by lr_front
module lr_back
    import lr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT,
    parameter int CMD_W = 1 + 2 + (COORD_BITS + 2) + 6 * COORD_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  logic [CMD_W-1:0]      cmd,
    output logic                  cmd_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last_pixel
);

    localparam int CB = COORD_BITS;

    logic              c_kind;
    logic              c_neg_x;
    logic              c_neg_y;
    logic signed [CB+1:0] c_err;
    logic [CB-1:0]     c_dy, c_dx, c_y1, c_x1, c_y0, c_x0;

    assign {c_kind, c_neg_x, c_neg_y, c_err, c_dy, c_dx, c_y1, c_x1, c_y0, c_x0} = cmd;

    logic [CB-1:0]        cur_x_reg, cur_x_next;
    logic [CB-1:0]        cur_y_reg, cur_y_next;
    logic [CB-1:0]        tgt_x_reg, tgt_x_next;
    logic [CB-1:0]        tgt_y_reg, tgt_y_next;
    logic [CB-1:0]        dx_reg, dx_next;
    logic [CB-1:0]        dy_reg, dy_next;
    logic                 neg_x_reg, neg_x_next;
    logic                 neg_y_reg, neg_y_next;
    logic signed [CB+1:0] err_reg, err_next;
    logic                 active_reg, active_next;
    logic                 out_valid_reg, out_valid_next;
    logic [CB-1:0]        pix_x_reg, pix_x_next;
    logic [CB-1:0]        pix_y_reg, pix_y_next;
    logic                 last_reg, last_next;

    logic                 is_start;
    logic                 load_out;
    logic signed [CB+2:0] e2;
    logic signed [CB+2:0] dx_ext;
    logic signed [CB+2:0] dy_ext;
    logic signed [CB+2:0] err_sum;
    logic                 step_x;
    logic                 step_y;
    logic [CB-1:0]        nx;
    logic [CB-1:0]        ny;

    // output stage takes a new item whenever it is empty or being drained
    assign cmd_pop  = cmd_valid && (!out_valid_reg || out_ready);
    assign is_start = kind_t'(c_kind) == KIND_START;
    assign load_out = cmd_pop && (is_start || active_reg);

    always_comb
    begin
        e2     = $signed({err_reg, 1'b0});
        dx_ext = $signed({3'b000, dx_reg});
        dy_ext = $signed({3'b000, dy_reg});
        step_x = e2 > -dy_ext;
        step_y = e2 < dx_ext;
        err_sum = $signed({err_reg[CB+1], err_reg})
                  - (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0);
        nx = cur_x_reg;
        ny = cur_y_reg;
        if (step_x)
            nx = neg_x_reg ? (cur_x_reg - CB'(1)) : (cur_x_reg + CB'(1));
        if (step_y)
            ny = neg_y_reg ? (cur_y_reg - CB'(1)) : (cur_y_reg + CB'(1));
    end

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        tgt_x_next     = tgt_x_reg;
        tgt_y_next     = tgt_y_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        neg_x_next     = neg_x_reg;
        neg_y_next     = neg_y_reg;
        err_next       = err_reg;
        active_next    = active_reg;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd_pop)
        begin
            if (is_start)
            begin
                cur_x_next = c_x0;
                cur_y_next = c_y0;
                tgt_x_next = c_x1;
                tgt_y_next = c_y1;
                dx_next    = c_dx;
                dy_next    = c_dy;
                neg_x_next = c_neg_x;
                neg_y_next = c_neg_y;
                err_next   = c_err;
                last_next  = (c_x0 == c_x1) && (c_y0 == c_y1);
            end
            else if (active_reg)
            begin
                cur_x_next = nx;
                cur_y_next = ny;
                err_next   = err_sum[CB+1:0];
                last_next  = (nx == tgt_x_reg) && (ny == tgt_y_reg);
            end
            // a step with no line in progress leaves everything as is
            if (load_out)
            begin
                pix_x_next  = cur_x_next;
                pix_y_next  = cur_y_next;
                active_next = !last_next;
            end
            out_valid_next = load_out;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        tgt_x_reg <= tgt_x_next;
        tgt_y_reg <= tgt_y_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        neg_x_reg <= neg_x_next;
        neg_y_reg <= neg_y_next;
        err_reg   <= err_next;
        pix_x_reg <= pix_x_next;
        pix_y_reg <= pix_y_next;
        last_reg  <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_x    = pix_x_reg;
    assign pixel_y    = pix_y_reg;
    assign last_pixel = last_reg;

`ifndef SYNTHESIS
    a_active_off_end: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cur_x_reg != tgt_x_reg) || (cur_y_reg != tgt_y_reg))
        else $error("line active while sitting on its end point");

    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && last_next |=> !active_reg)
        else $error("line still active after last pixel");

    a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && !is_start && !active_reg |=> !out_valid_reg)
        else $error("idle step produced a pixel");
`endif

endmodule

/* hdl/line_rasterizer_core.sv */
// line_rasterizer_core: top level of the bresenham line generator
// depends on lr_pkg, lr_front, lr_cmd_queue, lr_back
//
//   channel  signals                                   direction
//   input    in_valid/in_ready, kind, x/y start/end    into the block
//   output   out_valid/out_ready, pixel_x/y, last      out of the block
//
// one item per clock sustained while the output is not stalled; a result is registered
// in the command queue, then in the output register, before it can leave
// reset clears control only: queue pointers and count, line active flag, output valid
// either side may stall on its own; the queue absorbs up to QUEUE_DEPTH items
module line_rasterizer_core
    import lr_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [0:0]            kind,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last_pixel
);

    localparam int CMD_W = 1 + 2 + (COORD_BITS + 2) + 6 * COORD_BITS;

    logic [CMD_W-1:0] front_cmd;
    logic [CMD_W-1:0] queue_head;
    logic             queue_full;
    logic             queue_not_empty;
    logic             queue_pop;

    assign in_ready = !queue_full;

    lr_front #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .kind    (kind),
        .x_start (x_start),
        .y_start (y_start),
        .x_end   (x_end),
        .y_end   (y_end),
        .cmd     (front_cmd)
    );

    lr_cmd_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && in_ready),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head      (queue_head)
    );

    lr_back #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (queue_not_empty),
        .cmd        (queue_head),
        .cmd_pop    (queue_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

endmodule

/* tb/sv/tb_top.sv */
// tb_top: self-checking testbench for line_rasterizer_core, bresenham over all octants
// depends on lr_pkg and line_rasterizer_core; drives start/step commands, checks every pixel
// against a local line tracer, and runs four handshake pressure phases
module tb_top;
    import lr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COORD_BITS_DEFAULT;
    localparam int CMAX = (1 << CB) - 1;

    typedef struct packed {
        kind_t         op;
        logic [CB-1:0] xs;
        logic [CB-1:0] ys;
        logic [CB-1:0] xe;
        logic [CB-1:0] ye;
    } line_cmd_t;

    typedef struct packed {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic          is_end;
    } pixel_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [0:0]    kind = KIND_STEP;
    logic [CB-1:0] x_start = '0;
    logic [CB-1:0] y_start = '0;
    logic [CB-1:0] x_end = '0;
    logic [CB-1:0] y_end = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [CB-1:0] pixel_x;
    logic [CB-1:0] pixel_y;
    logic          last_pixel;

    line_rasterizer_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (last_pixel)
    );

    line_cmd_t cmd_backlog[$];
    pixel_t    pixel_expect[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int faults = 0;
    int n_starts = 0;
    int n_steps = 0;
    int n_ignored = 0;
    int n_checked = 0;
    int n_lines = 0;

    // line tracer state
    logic [CB-1:0] trace_x = '0;
    logic [CB-1:0] trace_y = '0;
    logic [CB-1:0] goal_x = '0;
    logic [CB-1:0] goal_y = '0;
    logic [CB-1:0] span_x = '0;
    logic [CB-1:0] span_y = '0;
    logic          dec_x = 1'b0;
    logic          dec_y = 1'b0;
    int            err_acc = 0;
    logic          line_live = 1'b0;

    initial
    begin
        forever #6 clk = ~clk;
    end

    // advances the traced line by one command; returns 0 when no pixel comes out
    function automatic bit trace_pixel(input line_cmd_t cmd, output pixel_t pix);
        int e2;
        int err;
        pix = '0;
        if (cmd.op == KIND_START)
        begin
            trace_x = cmd.xs;
            trace_y = cmd.ys;
            goal_x = cmd.xe;
            goal_y = cmd.ye;
            dec_x = !(cmd.xs < cmd.xe);
            dec_y = !(cmd.ys < cmd.ye);
            span_x = dec_x ? cmd.xs - cmd.xe : cmd.xe - cmd.xs;
            span_y = dec_y ? cmd.ys - cmd.ye : cmd.ye - cmd.ys;
            err_acc = int'(span_x) - int'(span_y);
        end
        else
        begin
            if (!line_live)
                return 1'b0;
            e2 = err_acc * 2;
            err = err_acc;
            if (e2 > -int'(span_y))
            begin
                err = err - int'(span_y);
                trace_x = dec_x ? trace_x - 1'b1 : trace_x + 1'b1;
            end
            if (e2 < int'(span_x))
            begin
                err = err + int'(span_x);
                trace_y = dec_y ? trace_y - 1'b1 : trace_y + 1'b1;
            end
            err_acc = err;
        end
        pix.px = trace_x;
        pix.py = trace_y;
        pix.is_end = (trace_x == goal_x) && (trace_y == goal_y);
        line_live = !pix.is_end;
        return 1'b1;
    endfunction

    // step commands carry random coordinates, which the block must ignore
    task automatic queue_steps(input int n);
        line_cmd_t cmd;
        for (int i = 0; i < n; i++)
        begin
            cmd.op = KIND_STEP;
            cmd.xs = CB'($urandom);
            cmd.ys = CB'($urandom);
            cmd.xe = CB'($urandom);
            cmd.ye = CB'($urandom);
            cmd_backlog.push_back(cmd);
        end
    endtask

    task automatic queue_line(input int xs, input int ys, input int xe, input int ye,
                              input int n);
        line_cmd_t cmd;
        cmd.op = KIND_START;
        cmd.xs = CB'(xs);
        cmd.ys = CB'(ys);
        cmd.xe = CB'(xe);
        cmd.ye = CB'(ye);
        cmd_backlog.push_back(cmd);
        queue_steps(n);
    endtask

    function automatic int near_coord(input int v);
        int d;
        d = $urandom_range(15);
        if ($urandom_range(1))
            d = -d;
        if (v + d < 0 || v + d > CMAX)
            d = -d;
        return v + d;
    endfunction

    function automatic int edge_coord();
        return $urandom_range(1) ? CMAX - $urandom_range(3) : $urandom_range(3);
    endfunction

    // mostly short complete lines; some cut short by a restart, some followed by
    // idle steps, a few long lines of at most 40 steps that are mostly abandoned part way
    task automatic queue_random_line(ref int counted);
        int x0, y0, x1, y1, len, n, mode, pick;
        mode = $urandom_range(9);
        if (mode == 9)
        begin
            x0 = $urandom_range(CMAX);
            y0 = $urandom_range(CMAX);
            x1 = $urandom_range(CMAX);
            y1 = $urandom_range(CMAX);
        end
        else
        begin
            x0 = (mode >= 7) ? edge_coord() : $urandom_range(CMAX);
            y0 = (mode >= 7) ? edge_coord() : $urandom_range(CMAX);
            x1 = near_coord(x0);
            y1 = near_coord(y0);
        end
        len = (x1 > x0) ? x1 - x0 : x0 - x1;
        if (((y1 > y0) ? y1 - y0 : y0 - y1) > len)
            len = (y1 > y0) ? y1 - y0 : y0 - y1;
        pick = $urandom_range(19);
        if (mode == 9)
            n = $urandom_range(40);
        else if (pick < 3)
            n = $urandom_range(len);
        else if (pick < 6)
            n = len + $urandom_range(1, 3);
        else
            n = len;
        if (mode == 9 && n > len)
            n = len;
        queue_line(x0, y0, x1, y1, n);
        counted += 1 + ((n < len) ? n : len);
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || in_valid || pixel_expect.size() != 0)
            @(negedge clk);
    endtask

    // sender side: predict on each transfer, then offer the next backlog entry
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        line_cmd_t cmd;
        pixel_t    pix;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind     <= KIND_STEP;
            x_start  <= '0;
            y_start  <= '0;
            x_end    <= '0;
            y_end    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                cmd.op = kind_t'(kind);
                cmd.xs = x_start;
                cmd.ys = y_start;
                cmd.xe = x_end;
                cmd.ye = y_end;
                if (cmd.op == KIND_START)
                    n_starts++;
                else
                    n_steps++;
                if (trace_pixel(cmd, pix))
                    pixel_expect.push_back(pix);
                else
                    n_ignored++;
            end
            if (!in_valid || in_ready)
            begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd = cmd_backlog.pop_front();
                    in_valid <= 1'b1;
                    kind     <= cmd.op;
                    x_start  <= cmd.xs;
                    y_start  <= cmd.ys;
                    x_end    <= cmd.xe;
                    y_end    <= cmd.ye;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver side: check each pixel transfer against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : watch_proc
        pixel_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pixel_expect.size() == 0)
                begin
                    $display("%0t ns: pixel with nothing expected: x=%0d y=%0d last=%0b",
                             $time, pixel_x, pixel_y, last_pixel);
                    faults++;
                end
                else
                begin
                    want = pixel_expect.pop_front();
                    n_checked++;
                    if (want.is_end)
                        n_lines++;
                    if (pixel_x !== want.px)
                    begin
                        $display("%0t ns: pixel_x expected %0d got %0d",
                                 $time, want.px, pixel_x);
                        faults++;
                    end
                    if (pixel_y !== want.py)
                    begin
                        $display("%0t ns: pixel_y expected %0d got %0d",
                                 $time, want.py, pixel_y);
                        faults++;
                    end
                    if (last_pixel !== want.is_end)
                    begin
                        $display("%0t ns: last_pixel expected %0b got %0b",
                                 $time, want.is_end, last_pixel);
                        faults++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : main_proc
        int budget;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < 4; ph++)
        begin
            unique case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 73;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 73;
                end
                default:
                begin
                    send_idle_pct = 33;
                    recv_stall_pct = 33;
                end
            endcase
            if (ph == 0)
            begin
                queue_steps(2);                         // nothing active after reset
                queue_line(0, 0, 0, 0, 1);              // single-pixel line, then idle step
                queue_line(CMAX, CMAX, CMAX, CMAX, 0);
                queue_line(10, 5, 12, 5, 2);            // horizontal
                queue_line(7, 9, 7, 7, 2);              // vertical, decreasing
                queue_line(100, 200, 98, 198, 2);       // diagonal, both decreasing
                queue_line(3, 4, 5, 3, 2);              // shallow, y decreasing
                queue_line(50, 50, 49, 52, 2);          // steep, x decreasing
                queue_line(0, 0, CMAX, CMAX, 1);        // abandoned by the next start
                queue_line(CMAX, 0, 0, CMAX, 1);
            end
            budget = 0;
            while (budget < 375)
                queue_random_line(budget);
            // sender holds off here until every pixel of the phase is back
            wait_drained();
        end
        repeat (10) @(posedge clk);
        $display("covered %0d line starts and %0d steps (%0d with no pixel)",
                 n_starts, n_steps, n_ignored);
        $display("checked %0d pixels over four pressure phases, %0d lines reached their end point",
                 n_checked, n_lines);
        if (faults == 0 && pixel_expect.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("timeout: %0d pixels still expected", pixel_expect.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
